@@ src/cadm_pkg.sv @@
// Shared operation codes, item types and constants for the decimal-capable ALU.
`default_nettype none

package cadm_pkg;

  // Operation codes carried in the request's tuser
  typedef enum logic [4:0] {
    OP_ADC = 5'd0,
    OP_AND = 5'd1,
    OP_ASL = 5'd2,
    OP_BIT = 5'd3,
    OP_CMP = 5'd4,
    OP_CPX = 5'd5,
    OP_CPY = 5'd6,
    OP_DEC = 5'd7,
    OP_EOR = 5'd8,
    OP_INC = 5'd9,
    OP_LD  = 5'd10,
    OP_LSR = 5'd11,
    OP_ORA = 5'd12,
    OP_ROL = 5'd13,
    OP_ROR = 5'd14,
    OP_SBC = 5'd15,
    OP_SLO = 5'd16
  } cadm_op_e;

  // Decimal correction constants
  localparam logic [3:0] NibbleMax   = 4'h9;
  localparam logic [3:0] NibbleFix   = 4'h6;
  localparam logic [9:0] DecHighMax  = 10'h09f;
  localparam logic [9:0] DecHighFix  = 10'h060;
  localparam logic [9:0] ByteMax     = 10'h0ff;

  // One operation request
  typedef struct packed {
    logic       decimal_flag;
    logic       overflow_in;
    logic       carry_in;
    logic [7:0] index_y;
    logic [7:0] index_x;
    logic [7:0] accumulator;
    logic [7:0] operand;
    logic [4:0] mode;
  } cadm_req_t;

  // One operation result
  typedef struct packed {
    logic       decimal_cycle;
    logic       negative_out;
    logic       zero_out;
    logic       overflow_out;
    logic       carry_out;
    logic [7:0] result;
  } cadm_rsp_t;

endpackage

`default_nettype wire

@@ src/cadm_alu.sv @@
// Combinational ALU function: logic, shift, compare and binary/decimal add and subtract.
`default_nettype none

module cadm_alu
  import cadm_pkg::*;
(
  input  wire cadm_req_t req_i,
  input  wire logic      decimal_support_i,
  output cadm_rsp_t      rsp_o
);

  logic [7:0] op;
  logic [7:0] acc;
  logic       is_sub;
  logic [7:0] addend;
  logic       dec_path;
  logic [8:0] bin_sum;
  logic       bin_ovf;
  logic [4:0] lo_raw;
  logic [5:0] lo_adj;
  logic       half_carry;
  logic [9:0] hi_sum;
  logic [9:0] dec_sum;
  logic [7:0] cmp_reg;
  logic [8:0] diff;
  logic [7:0] res;
  logic [7:0] zsrc;
  logic       nflag;
  logic       cflag;
  logic       vflag;
  logic       dcyc;

  assign op     = req_i.operand;
  assign acc    = req_i.accumulator;
  assign is_sub = (req_i.mode == OP_SBC);
  assign addend = is_sub ? ~op : op;

  // Binary add: 9-bit sum with signed overflow
  assign bin_sum = {1'b0, acc} + {1'b0, addend} + {8'd0, req_i.carry_in};
  assign bin_ovf = ~(acc[7] ^ addend[7]) & (acc[7] ^ bin_sum[7]);

  // Decimal add/subtract: low nibble correction, then high digit correction
  assign lo_raw = {1'b0, acc[3:0]} + {1'b0, addend[3:0]} + {4'd0, req_i.carry_in};

  always_comb begin
    lo_adj     = {1'b0, lo_raw};
    half_carry = 1'b0;
    if (!is_sub) begin
      if (lo_raw > {1'b0, NibbleMax}) begin
        lo_adj = {1'b0, lo_raw} + {2'd0, NibbleFix};
      end
      half_carry = (lo_adj > 6'h0f);
    end else begin
      half_carry = lo_raw[4];
      if (!half_carry) begin
        lo_adj = {1'b0, lo_raw} - {2'd0, NibbleFix};
      end
    end
  end

  assign hi_sum = {2'd0, acc[7:4], 4'd0} + {2'd0, addend[7:4], 4'd0}
                + {5'd0, half_carry, 4'd0} + {6'd0, lo_adj[3:0]};

  always_comb begin
    dec_sum = hi_sum;
    if (!is_sub) begin
      if (hi_sum > DecHighMax) begin
        dec_sum = hi_sum + DecHighFix;
      end
    end else begin
      if (hi_sum <= ByteMax) begin
        dec_sum = hi_sum - DecHighFix;
      end
    end
  end

  // Compare: register minus operand in 9 bits
  always_comb begin
    unique case (req_i.mode)
      OP_CPX:  cmp_reg = req_i.index_x;
      OP_CPY:  cmp_reg = req_i.index_y;
      default: cmp_reg = acc;
    endcase
  end

  assign diff     = {1'b0, cmp_reg} - {1'b0, op};
  assign dec_path = decimal_support_i & req_i.decimal_flag;

  // Select result and flags by operation
  always_comb begin
    res   = op;
    zsrc  = op;
    nflag = op[7];
    cflag = req_i.carry_in;
    vflag = req_i.overflow_in;
    dcyc  = 1'b0;
    unique case (req_i.mode)
      OP_ADC, OP_SBC: begin
        dcyc = dec_path;
        if (dec_path) begin
          res   = dec_sum[7:0];
          cflag = dec_sum[8];
        end else begin
          res   = bin_sum[7:0];
          cflag = bin_sum[8];
          vflag = bin_ovf;
        end
        zsrc  = res;
        nflag = res[7];
      end
      OP_AND: begin
        res   = acc & op;
        zsrc  = res;
        nflag = res[7];
      end
      OP_ASL: begin
        cflag = op[7];
        res   = {op[6:0], 1'b0};
        zsrc  = res;
        nflag = res[7];
      end
      OP_BIT: begin
        res   = acc;
        zsrc  = acc & op;
        nflag = op[7];
        vflag = op[6];
      end
      OP_CMP, OP_CPX, OP_CPY: begin
        cflag = ~diff[8];
        res   = cmp_reg;
        zsrc  = diff[7:0];
        nflag = diff[7];
      end
      OP_DEC: begin
        res   = op - 8'd1;
        zsrc  = res;
        nflag = res[7];
      end
      OP_EOR: begin
        res   = acc ^ op;
        zsrc  = res;
        nflag = res[7];
      end
      OP_INC: begin
        res   = op + 8'd1;
        zsrc  = res;
        nflag = res[7];
      end
      OP_LSR: begin
        cflag = op[0];
        res   = {1'b0, op[7:1]};
        zsrc  = res;
        nflag = 1'b0;
      end
      OP_ORA: begin
        res   = acc | op;
        zsrc  = res;
        nflag = res[7];
      end
      OP_ROL: begin
        cflag = op[7];
        res   = {op[6:0], req_i.carry_in};
        zsrc  = res;
        nflag = res[7];
      end
      OP_ROR: begin
        cflag = op[0];
        res   = {req_i.carry_in, op[7:1]};
        zsrc  = res;
        nflag = res[7];
      end
      OP_SLO: begin
        cflag = op[7];
        res   = acc | {op[6:0], 1'b0};
        zsrc  = res;
        nflag = res[7];
      end
      // Load and unused codes pass the operand
      default: begin
        res   = op;
        zsrc  = op;
        nflag = op[7];
      end
    endcase
  end

  assign rsp_o.result        = res;
  assign rsp_o.carry_out     = cflag;
  assign rsp_o.overflow_out  = vflag;
  assign rsp_o.zero_out      = (zsrc == 8'd0);
  assign rsp_o.negative_out  = nflag;
  assign rsp_o.decimal_cycle = dcyc;

endmodule

`default_nettype wire

@@ src/cpu_alu_with_decimal_mode.sv @@
// Top level: request register, ALU function and result register with stream handshakes.
//
// 8-bit processor ALU with optional decimal add and subtract. A request is
// accepted on s_axis when tvalid and tready are high, is captured in an input
// register, passes through the ALU function and lands in the result register,
// so a result passes the request register and then the result register, and
// one request is taken every clock cycle while m_axis keeps up. The request
// register advances when it is empty or the result register is free or being
// drained, so a waiting result stops new requests only once the request
// register also holds one. decimal_support (reset 1) enables the decimal path
// of add and subtract; write it only while no request is in flight.
`default_nettype none

module cpu_alu_with_decimal_mode
  import cadm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration: decimal_support
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  // Request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: operand[7:0], accumulator[15:8], index_x[23:16], index_y[31:24],
  //        carry_in[32], overflow_in[33], decimal_flag[34], zero[39:35]
  input  wire logic [39:0] s_axis_tdata,
  // tuser: mode[4:0]
  input  wire logic [4:0]  s_axis_tuser,
  // Result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: result[7:0], carry_out[8], overflow_out[9], zero_out[10],
  //        negative_out[11], decimal_cycle[12], zero[15:13]
  output logic [15:0]      m_axis_tdata
);

  logic      dec_support_q;
  logic      in_valid_q;
  cadm_req_t in_req_q;
  logic      out_valid_q;
  cadm_rsp_t out_rsp_q;
  cadm_rsp_t alu_rsp;
  logic      out_advance;
  logic      in_advance;

  // Hold the configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_support_q <= 1'b1;
    end else if (cfg_we_i) begin
      dec_support_q <= cfg_wdata_i;
    end
  end

  // Advance when this stage is empty or the stage ahead is free or draining
  assign out_advance   = !out_valid_q || m_axis_tready;
  assign in_advance    = !in_valid_q || out_advance;
  assign s_axis_tready = in_advance;

  // Request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_advance) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_advance && s_axis_tvalid) begin
      in_req_q.mode         <= s_axis_tuser;
      in_req_q.operand      <= s_axis_tdata[7:0];
      in_req_q.accumulator  <= s_axis_tdata[15:8];
      in_req_q.index_x      <= s_axis_tdata[23:16];
      in_req_q.index_y      <= s_axis_tdata[31:24];
      in_req_q.carry_in     <= s_axis_tdata[32];
      in_req_q.overflow_in  <= s_axis_tdata[33];
      in_req_q.decimal_flag <= s_axis_tdata[34];
    end
  end

  cadm_alu u_alu (
    .req_i             (in_req_q),
    .decimal_support_i (dec_support_q),
    .rsp_o             (alu_rsp)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_advance && in_valid_q) begin
      out_rsp_q <= alu_rsp;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'd0, out_rsp_q};

endmodule

`default_nettype wire
